>>> hw/rtl/sdf_pkg.sv
package sdf_pkg;

  // header layout
  localparam int unsigned LEN_BYTES = 4;
  localparam int unsigned CMD_BYTES = 2;
  localparam logic [23:0] MIN_FRAME_LENGTH = 24'(LEN_BYTES + CMD_BYTES);

  // parser phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  // result word kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_END = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_BYTE = 2'd0;
  localparam logic [1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  // reset values of configuration
  localparam logic [7:0]  RST_START_BYTE = 8'd2;
  localparam logic [7:0]  RST_END_BYTE   = 8'd3;
  localparam logic [23:0] RST_MAX_LENGTH = 24'd65535;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [23:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [15:0] command;
    logic [1:0]  frame_status;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/sdf_cfg_regs.sv
module sdf_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  output logic             cfg_ready,
  output sdf_pkg::cfg_t    cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= sdf_pkg::RST_START_BYTE;
      cfg.end_byte         <= sdf_pkg::RST_END_BYTE;
      cfg.max_frame_length <= sdf_pkg::RST_MAX_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdf_pkg::CFG_START_BYTE: cfg.start_byte       <= cfg_data[7:0];
        sdf_pkg::CFG_END_BYTE:   cfg.end_byte         <= cfg_data[7:0];
        sdf_pkg::CFG_MAX_LENGTH: cfg.max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sdf_parser.sv
module sdf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  sdf_pkg::cfg_t     cfg,
  output logic              res_valid,
  output sdf_pkg::result_t  res
);

  logic [2:0]  phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [23:0] length_value, length_value_next;
  logic [15:0] command_value, command_value_next;
  logic [23:0] payload_remaining, payload_remaining_next;
  logic [23:0] byte_shifted;

  // place the incoming byte at its length position
  assign byte_shifted = {16'd0, rx_byte} << {header_index, 3'b000};

  // next state and result for one word
  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    length_value_next      = length_value;
    command_value_next     = command_value;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res.item_kind          = sdf_pkg::KIND_DATA;
    res.data_byte          = 8'd0;
    res.command            = command_value;
    res.frame_status       = sdf_pkg::ST_GOOD;
    res.last               = 1'b0;
    case (phase)
      sdf_pkg::PH_LEN: begin
        header_index_next = header_index + 2'd1;
        if (header_index == 2'(sdf_pkg::LEN_BYTES - 1)) begin
          // top byte nonzero always exceeds the 24-bit limit
          if (rx_byte != 8'd0 || length_value < sdf_pkg::MIN_FRAME_LENGTH ||
              length_value > cfg.max_frame_length) begin
            phase_next       = sdf_pkg::PH_HUNT;
            res_valid        = 1'b1;
            res.item_kind    = sdf_pkg::KIND_STATUS;
            res.frame_status = sdf_pkg::ST_BAD_LEN;
            res.last         = 1'b1;
          end else begin
            payload_remaining_next = length_value - sdf_pkg::MIN_FRAME_LENGTH;
            phase_next             = sdf_pkg::PH_CMD;
          end
        end else begin
          length_value_next = length_value | byte_shifted;
        end
      end
      sdf_pkg::PH_CMD: begin
        if (header_index[0] == 1'b0) begin
          command_value_next[7:0] = rx_byte;
          header_index_next       = 2'd1;
        end else begin
          command_value_next[15:8] = rx_byte;
          header_index_next        = 2'd0;
          phase_next = (payload_remaining == 24'd0) ? sdf_pkg::PH_END : sdf_pkg::PH_DATA;
        end
      end
      sdf_pkg::PH_DATA: begin
        payload_remaining_next = payload_remaining - 24'd1;
        if (payload_remaining == 24'd1) begin
          phase_next = sdf_pkg::PH_END;
        end
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
      end
      sdf_pkg::PH_END: begin
        phase_next       = sdf_pkg::PH_HUNT;
        res_valid        = 1'b1;
        res.item_kind    = sdf_pkg::KIND_STATUS;
        res.frame_status = (rx_byte == cfg.end_byte) ? sdf_pkg::ST_GOOD
                                                     : sdf_pkg::ST_BAD_END;
        res.last         = 1'b1;
      end
      default: begin
        phase_next = sdf_pkg::PH_HUNT;
        if (rx_byte == cfg.start_byte) begin
          phase_next             = sdf_pkg::PH_LEN;
          header_index_next      = 2'd0;
          length_value_next      = 24'd0;
          command_value_next     = 16'd0;
          payload_remaining_next = 24'd0;
        end
      end
    endcase
  end

  // state advances only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sdf_pkg::PH_HUNT;
      header_index      <= 2'd0;
      length_value      <= 24'd0;
      command_value     <= 16'd0;
      payload_remaining <= 24'd0;
    end else if (accept) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      length_value      <= length_value_next;
      command_value     <= command_value_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

>>> hw/rtl/sdf_out_reg.sv
module sdf_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sdf_pkg::result_t  res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              space,
  output sdf_pkg::result_t  out_word
);

  // free when empty or draining this cycle
  assign space = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload holder
  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

endmodule

>>> hw/rtl/stx_etx_length_deframer_core.sv
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------------
// in      | input     | in_valid / in_ready   | rx_byte
// out     | output    | out_valid / out_ready | item_kind data_byte command frame_status last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// one received byte is taken per cycle while in_ready is high; a byte that yields a result word
// shows it in the next cycle from the single output register
// in_ready drops only while that register holds a word that is not taken
// reset (synchronous) returns to start-byte hunting and restores register defaults
// cfg_ready is always high
module stx_etx_length_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  data_byte,
  output logic [15:0] command,
  output logic [1:0]  frame_status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  sdf_pkg::cfg_t    cfg;
  sdf_pkg::result_t res;
  sdf_pkg::result_t out_word;
  logic             res_valid;
  logic             accept;
  logic             space;

  assign in_ready = space;
  assign accept   = in_valid && space;

  // configuration registers
  sdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // frame parser
  sdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  sdf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .space     (space),
    .out_word  (out_word)
  );

  assign item_kind    = out_word.item_kind;
  assign data_byte    = out_word.data_byte;
  assign command      = out_word.command;
  assign frame_status = out_word.frame_status;
  assign last         = out_word.last;

endmodule
